### rtl/fpg_pkg.sv
`default_nettype none
// ============================================================================
// fpg_pkg
// Shared constants, types and controller/datapath interface structs for the
// frame pacing governor.
// ============================================================================
package fpg_pkg;

    localparam int HIST_DEPTH   = 10;
    localparam int SLOT_W       = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int SWEEP_W      = $clog2(HIST_DEPTH + 1);

    localparam int TIME_W       = 32;
    localparam int MS_W         = 10;
    localparam int RATIO_W      = 9;
    localparam int UPD_W        = 4;
    localparam int PHASE_W      = 8;
    localparam int ACC_W        = PHASE_W + 1;

    localparam int DIVD_W       = 22;
    localparam int DIV_CNT_W    = $clog2(DIVD_W + 1);

    localparam int CLAMP_W      = 14;
    localparam int RECIP_W      = 13;
    localparam int PROD_W       = CLAMP_W + RECIP_W;
    localparam int RECIP_SHIFT  = 16;
    localparam int RECIP10      = 6554;

    localparam int FPS_PROD_W   = RATIO_W + 10;
    localparam int FPS_SHIFT    = 8;
    localparam int FPS_SCALE    = 1000;
    localparam int RATIO_SCALE  = 2560;

    localparam int CFG_IDX_W    = 1;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY    = 1'd1;

    localparam logic [MS_W-1:0]    PERIOD_RESET    = 10'd20;
    localparam logic [MS_W-1:0]    MIN_DELAY_RESET = 10'd1;
    localparam logic [MS_W-1:0]    DELAY_RESET     = 10'd1;
    localparam logic [MS_W-1:0]    DELAY_DEFAULT   = 10'd1;

    localparam logic [RATIO_W-1:0] RATIO_MIN   = 9'd25;
    localparam logic [RATIO_W-1:0] RATIO_FULL  = 9'd256;
    localparam logic [RATIO_W-1:0] RATIO_STALL = 9'd300;
    localparam logic [UPD_W-1:0]   UPD_MAX     = 4'd11;

    typedef struct packed {
        logic accept;
        logic load;
        logic decide;
        logic work_start;
        logic commit;
    } fpg_cmd_t;

    typedef struct packed {
        logic div_done;
        logic work_done;
    } fpg_status_t;

endpackage
`default_nettype wire

### rtl/frame_pacing_governor_top.sv
`default_nettype none
// ============================================================================
// frame_pacing_governor_top
// Frame pacing governor: speed ratio, sleep delay, update count and frame
// rate estimate from a ring of past frame times.
// ============================================================================
// One item at a time: a new input is taken only after the previous result has
// been committed to the output. The pace is set by two passes of the shared
// radix-2 divider (the history sweep runs beside the second pass).
// Reset: history cleared through per-entry valid bits, ratio 256, delay 1,
// phase 0, period 20 ms, minimum delay 1 ms; no clearing pass is needed.
module frame_pacing_governor_top
    import fpg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] now_ms
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [9:0] sleep_ms, [13:10] update_count,
                                              // [22:14] speed_ratio, [32:23] fps_estimate
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [MS_W-1:0]        cfg_data
);

    fpg_cmd_t           cmd;
    fpg_status_t        status;
    logic [MS_W-1:0]    period_reg;
    logic [MS_W-1:0]    min_delay_reg;
    logic [MS_W-1:0]    sleep_ms;
    logic [UPD_W-1:0]   update_count;
    logic [RATIO_W-1:0] speed_ratio;
    logic [MS_W-1:0]    fps_estimate;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            min_delay_reg <= MIN_DELAY_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRAME_PERIOD: period_reg    <= cfg_data;
                CFG_MIN_DELAY:    min_delay_reg <= cfg_data;
                default:          period_reg    <= period_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    fpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    fpg_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .now_ms       (s_tdata[TIME_W-1:0]),
        .period       (period_reg),
        .min_delay    (min_delay_reg),
        .sleep_ms     (sleep_ms),
        .update_count (update_count),
        .speed_ratio  (speed_ratio),
        .fps_estimate (fps_estimate)
    );

    assign m_tdata = OUT_TDATA_W'({fps_estimate, speed_ratio, update_count, sleep_ms});

endmodule
`default_nettype wire

### rtl/fpg_divider.sv
`default_nettype none
// ============================================================================
// fpg_divider
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ============================================================================
module fpg_divider
    import fpg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [DIVD_W-1:0]    quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [TIME_W:0]      rem_shift;
    logic [TIME_W:0]      rem_diff;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVD_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = DIV_CNT_W'(DIVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, divisor})
            begin
                rem_next = rem_diff[TIME_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[TIME_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("Divider finished without a division in progress.");

endmodule
`default_nettype wire

### rtl/fpg_datapath.sv
`default_nettype none
// ============================================================================
// fpg_datapath
// Frame time history, ratio and delay evaluation, phase stepping and the
// output result register.
// ============================================================================
module fpg_datapath
    import fpg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fpg_cmd_t          cmd,
    output fpg_status_t       status,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [MS_W-1:0]   period,
    input  logic [MS_W-1:0]   min_delay,
    output logic [MS_W-1:0]   sleep_ms,
    output logic [UPD_W-1:0]  update_count,
    output logic [RATIO_W-1:0] speed_ratio,
    output logic [MS_W-1:0]   fps_estimate
);

    localparam logic [SLOT_W:0]  DEPTH_S   = (SLOT_W + 1)'(HIST_DEPTH);
    localparam logic [SLOT_W:0]  LAST_S    = (SLOT_W + 1)'(HIST_DEPTH - 1);
    localparam logic [SWEEP_W-1:0] DEPTH_W = SWEEP_W'(HIST_DEPTH);

    logic [TIME_W-1:0]     hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] hist_valid_reg;
    logic [TIME_W-1:0]     rd_raw_reg;
    logic                  rd_valid_reg;
    logic [TIME_W-1:0]     rd_word;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    logic [TIME_W-1:0]     mem_wdata;

    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_safe;
    logic [SLOT_W-1:0]     slot_adv;

    logic [TIME_W-1:0]     now_reg;
    logic [TIME_W-1:0]     elapsed_reg;
    logic [TIME_W-1:0]     elapsed;
    logic                  past_zero_reg;
    logic                  elapsed_zero_reg;
    logic [PROD_W-1:0]     e10_prod_reg;
    logic [MS_W-1:0]       e10;

    logic [RATIO_W-1:0]    ratio_reg;
    logic [MS_W-1:0]       delay_reg;
    logic [MS_W-1:0]       sweep_amt_reg;
    logic [PHASE_W-1:0]    phase_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [UPD_W-1:0]      upd_cnt_reg;

    logic                  sweep_on_reg;
    logic [SWEEP_W-1:0]    sweep_cnt_reg;
    logic [SLOT_W-1:0]     sweep_widx;
    logic                  sweep_write;

    logic                  div_sel_reg;
    logic                  div_start;
    logic [DIVD_W-1:0]     div_dividend;
    logic [TIME_W-1:0]     div_divisor;
    logic                  div_busy;
    logic                  div_done;
    logic [DIVD_W-1:0]     div_quotient;
    logic [FPS_PROD_W-1:0] fps_prod;

    logic [DIVD_W-1:0]     raw_ratio;
    logic [MS_W-1:0]       delay_base;
    logic [MS_W:0]         pad_diff;
    logic [RATIO_W-1:0]    ratio_new;
    logic [MS_W-1:0]       delay_new;
    logic [MS_W-1:0]       delay_cap;
    logic [MS_W-1:0]       delay_floor;

    logic [MS_W-1:0]       sleep_out_reg;
    logic [UPD_W-1:0]      upd_out_reg;
    logic [RATIO_W-1:0]    ratio_out_reg;
    logic [MS_W-1:0]       fps_out_reg;

    // Read and write addressing of the history memory.
    always_comb
    begin
        slot_safe = ({1'b0, slot_reg} < DEPTH_S) ? slot_reg : '0;
        slot_adv  = ({1'b0, slot_safe} == LAST_S) ? '0 : slot_safe + 1'b1;
        if (sweep_on_reg && (sweep_cnt_reg < DEPTH_W))
        begin
            rd_addr = sweep_cnt_reg[SLOT_W-1:0];
        end
        else
        begin
            rd_addr = slot_safe;
        end
        sweep_widx  = SLOT_W'(sweep_cnt_reg - 1'b1);
        rd_word     = rd_valid_reg ? rd_raw_reg : '0;
        sweep_write = sweep_on_reg && (sweep_cnt_reg != '0) && (rd_word != '0);
        mem_we      = cmd.decide || sweep_write;
        mem_waddr   = cmd.decide ? slot_safe : sweep_widx;
        mem_wdata   = cmd.decide ? now_reg : rd_word + TIME_W'(sweep_amt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        rd_raw_reg <= hist_mem[rd_addr];
    end

    // Elapsed time, ratio, delay and divider operands.
    always_comb
    begin
        elapsed      = (now_reg > rd_word) ? now_reg - rd_word : '0;
        e10          = e10_prod_reg[RECIP_SHIFT +: MS_W];
        fps_prod     = FPS_PROD_W'(ratio_reg) * FPS_PROD_W'(FPS_SCALE);
        div_start    = cmd.load || cmd.work_start;
        div_dividend = cmd.load ? DIVD_W'(period) * DIVD_W'(RATIO_SCALE)
                                : DIVD_W'(fps_prod[FPS_PROD_W-1:FPS_SHIFT]);
        div_divisor  = div_sel_reg ? TIME_W'(period) : elapsed_reg;

        if (past_zero_reg)
        begin
            raw_ratio  = DIVD_W'(ratio_reg);
            delay_base = delay_reg;
        end
        else
        begin
            raw_ratio  = elapsed_zero_reg ? DIVD_W'(RATIO_STALL) : div_quotient;
            delay_base = DELAY_DEFAULT;
        end

        pad_diff  = {1'b0, period} - {1'b0, e10};
        ratio_new = raw_ratio[RATIO_W-1:0];
        delay_new = delay_base;
        if (raw_ratio < DIVD_W'(RATIO_MIN))
        begin
            ratio_new = RATIO_MIN;
        end
        else if (raw_ratio > DIVD_W'(RATIO_FULL))
        begin
            ratio_new = RATIO_FULL;
            delay_new = pad_diff[MS_W] ? '0 : pad_diff[MS_W-1:0];
        end
        delay_cap   = (delay_new > period) ? period : delay_new;
        delay_floor = (delay_cap < min_delay) ? min_delay : delay_cap;
    end

    fpg_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            slot_reg       <= '0;
            ratio_reg      <= RATIO_FULL;
            delay_reg      <= DELAY_RESET;
            phase_reg      <= '0;
            acc_reg        <= {1'b1, {PHASE_W{1'b0}}};
            upd_cnt_reg    <= '0;
            sweep_on_reg   <= 1'b0;
            sweep_cnt_reg  <= '0;
            div_sel_reg    <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= hist_valid_reg[rd_addr];
            if (cmd.load)
            begin
                div_sel_reg <= 1'b0;
            end
            if (cmd.decide)
            begin
                hist_valid_reg[slot_safe] <= 1'b1;
                slot_reg    <= slot_adv;
                ratio_reg   <= ratio_new;
                delay_reg   <= delay_floor;
                acc_reg     <= {1'b0, phase_reg};
                upd_cnt_reg <= '0;
            end
            else if (!acc_reg[PHASE_W])
            begin
                acc_reg     <= acc_reg + ACC_W'(ratio_reg);
                upd_cnt_reg <= upd_cnt_reg + 1'b1;
            end
            if (cmd.work_start)
            begin
                div_sel_reg   <= 1'b1;
                sweep_on_reg  <= (sweep_amt_reg > MS_W'(1));
                sweep_cnt_reg <= '0;
            end
            else if (sweep_on_reg)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == DEPTH_W)
                begin
                    sweep_on_reg <= 1'b0;
                end
            end
            if (cmd.commit)
            begin
                phase_reg <= acc_reg[PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            now_reg <= now_ms;
        end
        if (cmd.load)
        begin
            elapsed_reg      <= elapsed;
            past_zero_reg    <= (rd_word == '0);
            elapsed_zero_reg <= (elapsed == '0);
        end
        e10_prod_reg <= PROD_W'(elapsed_reg[CLAMP_W-1:0]) * PROD_W'(RECIP10);
        if (cmd.decide)
        begin
            sweep_amt_reg <= delay_cap;
        end
        if (cmd.commit)
        begin
            sleep_out_reg <= delay_reg;
            upd_out_reg   <= upd_cnt_reg;
            ratio_out_reg <= ratio_reg;
            fps_out_reg   <= (period == '0) ? '0 : div_quotient[MS_W-1:0];
        end
    end

    assign status.div_done  = div_done;
    assign status.work_done = !div_busy && !sweep_on_reg && acc_reg[PHASE_W];

    assign sleep_ms     = sleep_out_reg;
    assign update_count = upd_out_reg;
    assign speed_ratio  = ratio_out_reg;
    assign fps_estimate = fps_out_reg;

    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ratio_reg >= RATIO_MIN) && (ratio_reg <= RATIO_FULL))
        else $error("Stored speed ratio left its legal range.");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, slot_reg} < DEPTH_S)
        else $error("History slot index out of range.");

    a_update_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !acc_reg[PHASE_W] |-> (upd_cnt_reg < UPD_MAX))
        else $error("Phase stepping exceeded the update count bound.");

endmodule
`default_nettype wire

### rtl/fpg_ctrl.sv
`default_nettype none
// ============================================================================
// fpg_ctrl
// Sequencing state machine: input acceptance, divider passes, history update
// and the output transaction.
// ============================================================================
module fpg_ctrl
    import fpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output fpg_cmd_t    cmd,
    input  fpg_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_DECIDE,
        ST_START,
        ST_WORK,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_free       = !m_tvalid_reg || m_tready;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                cmd.work_start = 1'b1;
                state_next     = ST_WORK;
            end
            ST_WORK:
            begin
                if (status.work_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    a_commit_presents: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid_reg)
        else $error("Committed result was not presented on the output.");

endmodule
`default_nettype wire
